FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define PCTD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define PCTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pctd_pkg.sv
// Shared types, codes and helpers of the prefix code tree decoder.
package pctd_pkg;

    localparam int KIND_W      = 2;
    localparam int SYM_FIELD_W = 8;
    localparam int CODE_W      = 16;
    localparam int CODE_LEN_W  = 5;
    localparam int CODE_POS_W  = $clog2(CODE_W);

    typedef logic [KIND_W-1:0]      kind_t;
    typedef logic [SYM_FIELD_W-1:0] sym_field_t;
    typedef logic [CODE_W-1:0]      code_t;
    typedef logic [CODE_LEN_W-1:0]  code_len_t;

    // Transaction kinds; the fourth code is unused and ignored
    localparam kind_t KIND_ADD    = 2'd0;
    localparam kind_t KIND_DECODE = 2'd1;
    localparam kind_t KIND_END    = 2'd2;

    typedef enum logic [1:0] {
        STATUS_DECODED = 2'd0,
        STATUS_STORED  = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_NO_ROOT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_END,
        S_WALK,
        S_ALLOC,
        S_REPORT
    } state_t;

    // Code bit at a position; positions past the code field read as zero
    function automatic logic code_bit(code_t code, int unsigned pos);
        logic res;
        res = 1'b0;
        if (pos < CODE_W)
        begin
            res = code[pos[CODE_POS_W-1:0]];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/pctd_if.sv
// Valid/ready channel interfaces for input items and results.
interface pctd_item_if import pctd_pkg::*; ();
    logic      valid;
    logic      ready;
    kind_t     kind;
    sym_field_t symbol;
    code_t     code;
    code_len_t code_length;
    logic      bit_req;

    modport source (output valid, kind, symbol, code, code_length, bit_req, input ready);
    modport sink   (input valid, kind, symbol, code, code_length, bit_req, output ready);
endinterface

interface pctd_result_if import pctd_pkg::*; ();
    logic       valid;
    logic       ready;
    sym_field_t out_symbol;
    status_t    status;

    modport source (output valid, out_symbol, status, input ready);
    modport sink   (input valid, out_symbol, status, output ready);
endinterface

FILE: rtl/core/prefix_code_tree_decoder.sv
// Prefix code tree decoder: node table build and bit-serial decode.
// Decode: accept, then node evaluate. End: accept, then S_END, or accept only at the root.
// Add-code: accept, S_WALK over P existing nodes, S_ALLOC for A new nodes, then S_REPORT
// (P + A <= MAX_CODE_LEN), one tree level per cycle; the unused kind is only accepted.
// One transaction at a time; a stalled result holds the block until it drains.
// Reset clears control and the root, sets the free index to 1; nodes are written whole.
module prefix_code_tree_decoder import pctd_pkg::*; #(
    parameter int NODE_COUNT   = 512,
    parameter int MAX_CODE_LEN = 16,
    parameter int SYMBOL_BITS  = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    pctd_item_if.sink     item,
    pctd_result_if.source result
);

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int CNT_W = $clog2(NODE_COUNT + 1);
    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

    // One tree node: per direction a valid mark and child index, plus symbol
    typedef struct packed {
        logic [1:0]            valid;
        logic [1:0][IDX_W-1:0] child;
        logic [SYMBOL_BITS-1:0] sym;
    } node_t;

    // Node memory; entry 0 is unused, the root lives in root_reg
    node_t node_mem [NODE_COUNT];

    state_t state_reg, state_next;

    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] next_free_reg, next_free_next;
    node_t            root_reg, root_next;
    logic             out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]       node_reg, node_next;
    logic [LEN_W-1:0]       rem_reg, rem_next;
    code_t                  code_reg, code_next;
    logic [SYMBOL_BITS-1:0] sym_reg, sym_next;
    logic                   bit_reg, bit_next;
    status_t                pend_status_reg, pend_status_next;
    sym_field_t             out_symbol_reg, out_symbol_next;
    status_t                out_status_reg, out_status_next;

    node_t            rd_data_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    node_t            wr_data;

    logic             accept;
    logic             slot_free;
    logic             out_load;
    logic [LEN_W-1:0] len_sat;
    node_t            walk_ent;
    node_t            cur_ent;
    logic             walk_bit;
    logic             fits;
    node_t            new_node;

    assign accept    = item.valid && item.ready;
    // The result register is free if empty or being drained this cycle
    assign slot_free = !out_valid_reg || result.ready;

    assign len_sat = (32'(item.code_length) > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN)
                                                            : LEN_W'(item.code_length);

    // Entry of the node under evaluation: root from flops, others from memory
    assign walk_ent = (node_reg == '0) ? root_reg : rd_data_reg;
    assign cur_ent  = (cur_reg == '0) ? root_reg : rd_data_reg;
    assign walk_bit = code_bit(code_reg, 32'(rem_reg - LEN_W'(1)));
    // Remaining bits each need one fresh node once the walk leaves the tree
    assign fits     = (32'(next_free_reg) + 32'(rem_reg)) <= NODE_COUNT;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.kind)
                        KIND_ADD:    state_next = S_WALK;
                        KIND_DECODE: state_next = S_DECODE;
                        KIND_END:    state_next = (cur_reg == '0) ? S_IDLE : S_END;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_DECODE:
            begin
                if (cur_ent.valid[bit_reg] || slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_END:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (rem_reg == '0)
                begin
                    state_next = S_REPORT;
                end
                else if (!walk_ent.valid[walk_bit])
                begin
                    state_next = fits ? S_ALLOC : S_REPORT;
                end
            end
            S_ALLOC:
            begin
                if (rem_reg == '0)
                begin
                    state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, memory control and result loading
    always_comb
    begin
        item.ready       = (state_reg == S_IDLE);
        cur_next         = cur_reg;
        next_free_next   = next_free_reg;
        root_next        = root_reg;
        node_next        = node_reg;
        rem_next         = rem_reg;
        code_next        = code_reg;
        sym_next         = sym_reg;
        bit_next         = bit_reg;
        pend_status_next = pend_status_reg;
        rd_en            = 1'b0;
        rd_addr          = cur_reg;
        wr_en            = 1'b0;
        wr_addr          = node_reg;
        wr_data          = walk_ent;
        out_load         = 1'b0;
        out_symbol_next  = out_symbol_reg;
        out_status_next  = out_status_reg;
        new_node         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    code_next = item.code;
                    sym_next  = SYMBOL_BITS'(item.symbol);
                    bit_next  = item.bit_req;
                    rem_next  = len_sat;
                    node_next = '0;
                    // Fetch the current node for decode and end; the root is in flops
                    if ((item.kind == KIND_DECODE || item.kind == KIND_END) && cur_reg != '0)
                    begin
                        rd_en = 1'b1;
                    end
                end
            end
            S_DECODE:
            begin
                if (cur_ent.valid[bit_reg])
                begin
                    cur_next = cur_ent.child[bit_reg];
                end
                else if (slot_free)
                begin
                    out_load = 1'b1;
                    if (cur_reg == '0)
                    begin
                        // No branch at the root: report and drop the bit
                        out_symbol_next = '0;
                        out_status_next = STATUS_NO_ROOT;
                    end
                    else
                    begin
                        // Emit the pending symbol and retake the bit at the root
                        out_symbol_next = SYM_FIELD_W'(cur_ent.sym);
                        out_status_next = STATUS_DECODED;
                        cur_next = root_reg.valid[bit_reg] ? root_reg.child[bit_reg] : '0;
                    end
                end
            end
            S_END:
            begin
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_symbol_next = SYM_FIELD_W'(cur_ent.sym);
                    out_status_next = STATUS_DECODED;
                    cur_next        = '0;
                end
            end
            S_WALK:
            begin
                if (rem_reg == '0)
                begin
                    // Path already exists: set the symbol of its last node
                    pend_status_next = STATUS_STORED;
                    if (node_reg == '0)
                    begin
                        root_next.sym = sym_reg;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_data.sym = sym_reg;
                    end
                end
                else if (walk_ent.valid[walk_bit])
                begin
                    // Descend one level and fetch the child
                    rd_en     = 1'b1;
                    rd_addr   = walk_ent.child[walk_bit];
                    node_next = walk_ent.child[walk_bit];
                    rem_next  = rem_reg - LEN_W'(1);
                end
                else if (!fits)
                begin
                    pend_status_next = STATUS_FULL;
                end
                else
                begin
                    // Link the parent to the first fresh node
                    rem_next = rem_reg - LEN_W'(1);
                    if (node_reg == '0)
                    begin
                        root_next.valid[walk_bit] = 1'b1;
                        root_next.child[walk_bit] = IDX_W'(next_free_reg);
                    end
                    else
                    begin
                        wr_en                   = 1'b1;
                        wr_data.valid[walk_bit] = 1'b1;
                        wr_data.child[walk_bit] = IDX_W'(next_free_reg);
                    end
                end
            end
            S_ALLOC:
            begin
                // Write one fresh node; chain it to the next one or close with the symbol
                wr_en          = 1'b1;
                wr_addr        = IDX_W'(next_free_reg);
                next_free_next = CNT_W'(next_free_reg + CNT_W'(1));
                if (rem_reg == '0)
                begin
                    new_node.sym     = sym_reg;
                    pend_status_next = STATUS_STORED;
                end
                else
                begin
                    new_node.valid[walk_bit] = 1'b1;
                    new_node.child[walk_bit] = IDX_W'(next_free_reg + CNT_W'(1));
                    rem_next                 = rem_reg - LEN_W'(1);
                end
                wr_data = new_node;
            end
            S_REPORT:
            begin
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_symbol_next = '0;
                    out_status_next = pend_status_reg;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    end

    assign result.valid      = out_valid_reg;
    assign result.out_symbol = out_symbol_reg;
    assign result.status     = out_status_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            next_free_reg <= CNT_W'(1);
            root_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            next_free_reg <= next_free_next;
            root_reg      <= root_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        node_reg        <= node_next;
        rem_reg         <= rem_next;
        code_reg        <= code_next;
        sym_reg         <= sym_next;
        bit_reg         <= bit_next;
        pend_status_reg <= pend_status_next;
        out_symbol_reg  <= out_symbol_next;
        out_status_reg  <= out_status_next;
    end

    // Node memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/pctd_checker.sv
// Port-level assertion checker for the prefix code tree decoder, with its bind.
`include "assert_macros.svh"

module pctd_checker import pctd_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input kind_t      item_kind,
    input logic       res_valid,
    input logic       res_ready,
    input sym_field_t out_symbol,
    input status_t    status
);

    // Hold a stalled result
    `PCTD_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid, "result dropped while stalled")
    `PCTD_ASSERT_NEXT(a_res_stable, clk, rst_n, res_valid && !res_ready, $stable(out_symbol) && $stable(status), "stalled result changed")
    // Only decoded symbols carry a symbol value
    `PCTD_ASSERT_SAME(a_sym_zero, clk, rst_n, res_valid && status != STATUS_DECODED, out_symbol == '0, "symbol set on non-decode status")
    // An add-code transaction always walks the tree before the next one
    `PCTD_ASSERT_NEXT(a_add_busy, clk, rst_n, item_valid && item_ready && item_kind == KIND_ADD, !item_ready, "ready during code insertion")

endmodule

bind prefix_code_tree_decoder pctd_checker u_pctd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .item_kind  (item.kind),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .out_symbol (result.out_symbol),
    .status     (result.status)
);
